// ----- hw/rtl/vecrot_pkg.sv -----
// shared constants, codes and angle-table functions for the vector axis rotation core
`default_nettype none

package vecrot_pkg;

  // default sizes
  localparam int COORD_BITS_DEF    = 32;
  localparam int ANGLE_BITS_DEF    = 32;
  localparam int CORDIC_STAGES_DEF = 24;

  // axis codes
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // cordic gain compensation 1/K in Q32, 1/(2pi) in Q64
  localparam logic [31:0] GAIN_Q32       = 32'h9B74EDA8;
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;

  // low slice width of the split gain multiply
  localparam int MUL_LO_BITS = 32;

  // guard bits below the coordinate lsb inside the cordic
  function automatic int guard_bits(input int coord_bits);
    int g;
    g = 60 - coord_bits;
    if (g > 28) begin
      g = 28;
    end
    return g;
  endfunction

  // restoring shift-subtract quotient, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) as a fraction of a turn, units of 2^-62 turn
  function automatic logic [63:0] cordic_angle(input int i);
    logic [63:0]  r;
    logic [63:0]  term;
    logic [127:0] prod;
    logic [63:0]  hi;
    int           e;
    r = '0;
    if (i == 0) begin
      return 64'd1 << 59;
    end
    for (int k = 0; k < 33; k++) begin
      if ((2 * k + 1) * i <= 64) begin
        e = 64 - (2 * k + 1) * i;
        if (e <= 63) begin
          term = udiv64(64'd1 << e, 64'(2 * k + 1));
          if ((k % 2) == 1) begin
            r = r - term;
          end else begin
            r = r + term;
          end
        end
      end
    end
    prod = {64'd0, r} * {64'd0, INV_TWO_PI_Q64};
    hi   = prod[127:64];
    return (hi + 64'd2) >> 2;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vector_axis_rotation_core.sv -----
// top level: pipelined cordic rotation of a 3-d vector about one coordinate axis
//
//  channel | direction | ports                                                 | handshake
//  --------+-----------+-------------------------------------------------------+------------------
//  in      | input     | in_req_type, in_x_in, in_y_in, in_z_in, in_turn_angle | in_valid/in_stall
//  out     | output    | out_x_out, out_y_out, out_z_out                       | out_valid/out_stall
//
//  one item enters per cycle while the output is not stalled; the registers in order are
//  (quadrant stage, one register per unrolled cordic stage, abs, split gain multiply,
//  rounding, saturation/output register)
//  the gain multiply is cut into two partial products of at most 32 by 32 bits per coordinate
//  reset (rst_n low, synchronous) clears only the valid bits
//  a stalled output freezes the whole pipeline, in_stall follows it the same cycle
`default_nettype none

module vector_axis_rotation_core
  import vecrot_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire        [1:0]              in_req_type,
  input  wire signed [COORD_BITS-1:0]   in_x_in,
  input  wire signed [COORD_BITS-1:0]   in_y_in,
  input  wire signed [COORD_BITS-1:0]   in_z_in,
  input  wire        [ANGLE_BITS-1:0]   in_turn_angle,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [COORD_BITS-1:0]  out_x_out,
  output logic signed [COORD_BITS-1:0]  out_y_out,
  output logic signed [COORD_BITS-1:0]  out_z_out
);

  localparam int GUARD = guard_bits(COORD_BITS);
  localparam int PW    = COORD_BITS + 1;            // coordinate after quarter turn
  localparam int DW    = COORD_BITS + GUARD + 3;    // cordic datapath
  localparam int ML    = DW - 1;                    // magnitude width
  localparam int PRODW = ML + MUL_LO_BITS;          // gain product width
  localparam int SHIFT = MUL_LO_BITS + GUARD;       // bits dropped by rounding
  localparam int RW    = PRODW - SHIFT;             // rounded magnitude width
  localparam int EW    = COORD_BITS + 3;            // width ahead of saturation
  localparam int NS    = CORDIC_STAGES;

  localparam logic [ANGLE_BITS-1:0] EIGHTH   = {3'b001, {(ANGLE_BITS-3){1'b0}}};
  localparam logic [PRODW-1:0]      RND_HALF = {{(PRODW-1){1'b0}}, 1'b1} << (SHIFT - 1);
  localparam logic signed [EW-1:0]  SAT_HI   = {4'b0000, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [EW-1:0]  SAT_LO   = {4'b1111, {(COORD_BITS-1){1'b0}}};

  // per-item information that rides alongside the cordic datapath
  typedef struct packed {
    logic [1:0]           axis;
    logic                 rot;
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] z;
  } side_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[COORD_BITS-1:0];
  endfunction

  // global advance: everything moves unless a finished result is held
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // ---------------------------------------------------------------------
  // quadrant reduction and exact quarter turn
  logic [ANGLE_BITS-1:0]     q_sum;
  logic [1:0]                quad;
  logic [ANGLE_BITS-1:0]     resid;
  logic                      do_turn;
  logic signed [PW-1:0]      xe, ye, ze, pu, pw, tu, tw;
  logic signed [DW-1:0]      u0_nxt, w0_nxt;
  logic [63:0]               z0_nxt;
  side_t                     side0_nxt;

  always_comb begin
    q_sum   = in_turn_angle + EIGHTH;
    quad    = q_sum[ANGLE_BITS-1 -: 2];
    resid   = in_turn_angle - {quad, {(ANGLE_BITS-2){1'b0}}};
    do_turn = (in_turn_angle != '0) && (in_req_type != AXIS_NONE);
    xe = {in_x_in[COORD_BITS-1], in_x_in};
    ye = {in_y_in[COORD_BITS-1], in_y_in};
    ze = {in_z_in[COORD_BITS-1], in_z_in};
    // pair in the plane of rotation
    case (in_req_type)
      AXIS_X: begin
        pu = ye;
        pw = ze;
      end
      AXIS_Y: begin
        pu = ze;
        pw = xe;
      end
      default: begin
        pu = xe;
        pw = ye;
      end
    endcase
    // exact quarter turns by swap and negate
    case (quad)
      2'd1: begin
        tu = -pw;
        tw = pu;
      end
      2'd2: begin
        tu = -pu;
        tw = -pw;
      end
      2'd3: begin
        tu = pw;
        tw = -pu;
      end
      default: begin
        tu = pu;
        tw = pw;
      end
    endcase
    side0_nxt.axis = in_req_type;
    side0_nxt.rot  = do_turn && (resid != '0);
    side0_nxt.x    = xe;
    side0_nxt.y    = ye;
    side0_nxt.z    = ze;
    if (do_turn) begin
      case (in_req_type)
        AXIS_X: begin
          side0_nxt.y = tu;
          side0_nxt.z = tw;
        end
        AXIS_Y: begin
          side0_nxt.z = tu;
          side0_nxt.x = tw;
        end
        default: begin
          side0_nxt.x = tu;
          side0_nxt.y = tw;
        end
      endcase
    end
    u0_nxt = {{2{tu[PW-1]}}, tu, {GUARD{1'b0}}};
    w0_nxt = {{2{tw[PW-1]}}, tw, {GUARD{1'b0}}};
    z0_nxt = {{(64-ANGLE_BITS){resid[ANGLE_BITS-1]}}, resid} << (62 - ANGLE_BITS);
  end

  // ---------------------------------------------------------------------
  // unrolled cordic stages, one register each
  logic                 vld_r  [0:NS];
  side_t                side_r [0:NS];
  logic signed [DW-1:0] cu_r   [0:NS];
  logic signed [DW-1:0] cw_r   [0:NS];
  logic [63:0]          cz_r   [0:NS];
  logic signed [DW-1:0] cu_nxt [1:NS];
  logic signed [DW-1:0] cw_nxt [1:NS];
  logic [63:0]          cz_nxt [1:NS];

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam logic [63:0] ANG = cordic_angle(i);
    logic signed [DW-1:0] du, dw;
    always_comb begin
      du = cu_r[i] >>> i;
      dw = cw_r[i] >>> i;
      // z negative: rotate back
      if (cz_r[i][63]) begin
        cu_nxt[i+1] = cu_r[i] + dw;
        cw_nxt[i+1] = cw_r[i] - du;
        cz_nxt[i+1] = cz_r[i] + ANG;
      end else begin
        cu_nxt[i+1] = cu_r[i] - dw;
        cw_nxt[i+1] = cw_r[i] + du;
        cz_nxt[i+1] = cz_r[i] - ANG;
      end
    end
  end

  // valid bits of the front section
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= NS; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // front section payload
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side0_nxt;
      cu_r[0]   <= u0_nxt;
      cw_r[0]   <= w0_nxt;
      cz_r[0]   <= z0_nxt;
      for (int i = 1; i <= NS; i++) begin
        side_r[i] <= side_r[i-1];
        cu_r[i]   <= cu_nxt[i];
        cw_r[i]   <= cw_nxt[i];
        cz_r[i]   <= cz_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // gain compensation: magnitude, split multiply, round half away from zero
  logic                 mag_vld_r, pp_vld_r, rnd_vld_r;
  side_t                mag_side_r, pp_side_r, rnd_side_r;
  logic                 mag_su_r, mag_sw_r, pp_su_r, pp_sw_r, rnd_su_r, rnd_sw_r;
  logic [ML-1:0]        mag_u_r, mag_w_r;
  logic [DW-1:0]        abs_u, abs_w;
  logic [63:0]          pp_ulo_r, pp_wlo_r, pp_ulo_nxt, pp_wlo_nxt;
  logic [ML-1:0]        pp_uhi_r, pp_whi_r, pp_uhi_nxt, pp_whi_nxt;
  logic [PRODW-1:0]     full_u, full_w;
  logic [RW-1:0]        rnd_u_r, rnd_w_r;

  always_comb begin
    abs_u = cu_r[NS][DW-1] ? DW'(-cu_r[NS]) : DW'(cu_r[NS]);
    abs_w = cw_r[NS][DW-1] ? DW'(-cw_r[NS]) : DW'(cw_r[NS]);
    pp_ulo_nxt = {32'd0, mag_u_r[MUL_LO_BITS-1:0]} * {32'd0, GAIN_Q32};
    pp_wlo_nxt = {32'd0, mag_w_r[MUL_LO_BITS-1:0]} * {32'd0, GAIN_Q32};
    pp_uhi_nxt = {{MUL_LO_BITS{1'b0}}, mag_u_r[ML-1:MUL_LO_BITS]}
               * {{(ML-MUL_LO_BITS){1'b0}}, GAIN_Q32};
    pp_whi_nxt = {{MUL_LO_BITS{1'b0}}, mag_w_r[ML-1:MUL_LO_BITS]}
               * {{(ML-MUL_LO_BITS){1'b0}}, GAIN_Q32};
    full_u = {pp_uhi_r, {MUL_LO_BITS{1'b0}}} + {{(PRODW-64){1'b0}}, pp_ulo_r} + RND_HALF;
    full_w = {pp_whi_r, {MUL_LO_BITS{1'b0}}} + {{(PRODW-64){1'b0}}, pp_wlo_r} + RND_HALF;
  end

  // valid bits of the back section
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_vld_r   <= 1'b0;
      pp_vld_r    <= 1'b0;
      rnd_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      mag_vld_r   <= vld_r[NS];
      pp_vld_r    <= mag_vld_r;
      rnd_vld_r   <= pp_vld_r;
      out_valid_r <= rnd_vld_r;
    end
  end

  // back section payload
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_side_r <= side_r[NS];
      mag_su_r   <= cu_r[NS][DW-1];
      mag_sw_r   <= cw_r[NS][DW-1];
      mag_u_r    <= abs_u[ML-1:0];
      mag_w_r    <= abs_w[ML-1:0];
      pp_side_r  <= mag_side_r;
      pp_su_r    <= mag_su_r;
      pp_sw_r    <= mag_sw_r;
      pp_ulo_r   <= pp_ulo_nxt;
      pp_wlo_r   <= pp_wlo_nxt;
      pp_uhi_r   <= pp_uhi_nxt;
      pp_whi_r   <= pp_whi_nxt;
      rnd_side_r <= pp_side_r;
      rnd_su_r   <= pp_su_r;
      rnd_sw_r   <= pp_sw_r;
      rnd_u_r    <= full_u[SHIFT +: RW];
      rnd_w_r    <= full_w[SHIFT +: RW];
    end
  end

  // ---------------------------------------------------------------------
  // sign restore, result selection and saturation into the output register
  logic signed [EW-1:0]         ru, rw;
  logic signed [COORD_BITS-1:0] out_x_nxt, out_y_nxt, out_z_nxt;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r, out_z_r;
  logic signed [COORD_BITS-1:0] su_sat, sw_sat;

  always_comb begin
    ru = rnd_su_r ? -$signed({1'b0, rnd_u_r}) : $signed({1'b0, rnd_u_r});
    rw = rnd_sw_r ? -$signed({1'b0, rnd_w_r}) : $signed({1'b0, rnd_w_r});
    su_sat    = sat_coord(ru);
    sw_sat    = sat_coord(rw);
    out_x_nxt = sat_coord({{2{rnd_side_r.x[PW-1]}}, rnd_side_r.x});
    out_y_nxt = sat_coord({{2{rnd_side_r.y[PW-1]}}, rnd_side_r.y});
    out_z_nxt = sat_coord({{2{rnd_side_r.z[PW-1]}}, rnd_side_r.z});
    if (rnd_side_r.rot) begin
      case (rnd_side_r.axis)
        AXIS_X: begin
          out_y_nxt = su_sat;
          out_z_nxt = sw_sat;
        end
        AXIS_Y: begin
          out_z_nxt = su_sat;
          out_x_nxt = sw_sat;
        end
        AXIS_Z: begin
          out_x_nxt = su_sat;
          out_y_nxt = sw_sat;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r <= out_x_nxt;
      out_y_r <= out_y_nxt;
      out_z_r <= out_z_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x_out = out_x_r;
  assign out_y_out = out_y_r;
  assign out_z_out = out_z_r;

  // ---------------------------------------------------------------------
  // checks

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

  // a zero angle never enters the cordic path
  a_zero_no_rot: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_turn_angle == '0)) |=> !side_r[0].rot)
    else $error("zero angle marked for cordic rotation");

  // a held result freezes the end of the cordic section
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(vld_r[NS]) && $stable(cu_r[NS])
                                    && $stable(cw_r[NS])))
    else $error("pipeline moved while output stalled");

  // an output only appears from a valid rounding stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(rnd_vld_r))
    else $error("output valid without a rounded item");

endmodule

`default_nettype wire

// ----- tb/vector_axis_rotation_core_tb.sv -----
// self-checking testbench for the vector axis rotation core
module vector_axis_rotation_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vecrot_pkg::*;

  localparam int COORD_W = 32;
  localparam int ANGLE_W = 32;
  localparam int STAGES = 24;
  localparam int GUARD = 28;
  localparam int DRAIN_CYCLES = STAGES + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 488;
  localparam int REPORT_LIMIT = 10;

  localparam logic [63:0] TURN_PER_RADIAN_Q64 = 64'h28BE60DB9391054A;
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;
  localparam logic [ANGLE_W-1:0] QUARTER = 32'h40000000;
  localparam logic [ANGLE_W-1:0] HALF = 32'h80000000;
  localparam logic [ANGLE_W-1:0] THREE_QUARTER = 32'hC0000000;
  localparam logic [ANGLE_W-1:0] EIGHTH = 32'h20000000;

  typedef struct {
    logic [1:0]                axis;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [ANGLE_W-1:0]        angle;
  } rot_request_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } rot_vector_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_req_type = AXIS_X;
  logic signed [COORD_W-1:0] in_x_in = '0;
  logic signed [COORD_W-1:0] in_y_in = '0;
  logic signed [COORD_W-1:0] in_z_in = '0;
  logic [ANGLE_W-1:0]        in_turn_angle = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_x_out;
  logic signed [COORD_W-1:0] out_y_out;
  logic signed [COORD_W-1:0] out_z_out;

  rot_request_t pending_requests[$];
  rot_vector_t  expected_vectors[$];
  longint       atan_step[STAGES];
  rot_request_t next_req;
  rot_request_t taken_req;
  rot_vector_t  want;
  logic         in_taken = 1'b0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           error_count = 0;
  int           quiet_cycles = 0;

  vector_axis_rotation_core #(
    .COORD_BITS   (COORD_W),
    .ANGLE_BITS   (ANGLE_W),
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_x_in      (in_x_in),
    .in_y_in      (in_y_in),
    .in_z_in      (in_z_in),
    .in_turn_angle(in_turn_angle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x_out    (out_x_out),
    .out_y_out    (out_y_out),
    .out_z_out    (out_z_out)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // atan(2^-i) in units of 2^-62 turn, from the alternating series in q64 radians
  function automatic longint atan_turns(input int i);
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [127:0] prod;
    int           e;
    acc = '0;
    if (i == 0) begin
      return longint'(64'd1 << 59);
    end
    for (int k = 0; (2 * k + 1) * i <= 64; k++) begin
      e = 64 - (2 * k + 1) * i;
      if (e <= 63) begin
        term = (64'd1 << e) / 64'(2 * k + 1);
        acc = (k % 2 == 1) ? acc - term : acc + term;
      end
    end
    prod = {64'd0, acc} * {64'd0, TURN_PER_RADIAN_Q64};
    return longint'((prod[127:64] + 64'd2) >> 2);
  endfunction

  // undo the cordic gain and drop the guard bits, round half away from zero
  function automatic longint remove_gain(input longint v);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    prod = {64'd0, mag} * {96'd0, INV_GAIN_Q32};
    prod = (prod + (128'd1 << (31 + GUARD))) >> (32 + GUARD);
    return (v < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > longint'(COORD_MAX)) begin
      return COORD_MAX;
    end else if (v < longint'(COORD_MIN)) begin
      return COORD_MIN;
    end
    return v[COORD_W-1:0];
  endfunction

  // turn the (u, w) pair: exact quarter turns first, then cordic on the residual
  function automatic void turn_pair(inout longint u, inout longint w,
                                    input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W:0]   qsum;
    logic [1:0]         quad;
    logic [ANGLE_W-1:0] resid;
    longint             r;
    longint             zacc;
    longint             t;
    longint             du;
    longint             dw;
    qsum = {1'b0, a} + (33'd1 << (ANGLE_W - 3));
    quad = qsum[ANGLE_W-1:ANGLE_W-2];
    resid = a - {quad, {(ANGLE_W - 2){1'b0}}};
    r = longint'(signed'(resid));
    case (quad)
      2'd1: begin
        t = u; u = -w; w = t;
      end
      2'd2: begin
        u = -u; w = -w;
      end
      2'd3: begin
        t = u; u = w; w = -t;
      end
      default: ;
    endcase
    if (r != 0) begin
      u = u * (longint'(1) << GUARD);
      w = w * (longint'(1) << GUARD);
      zacc = r * (longint'(1) << (62 - ANGLE_W));
      for (int i = 0; i < STAGES; i++) begin
        du = w >>> i;
        dw = u >>> i;
        if (zacc >= 0) begin
          u -= du; w += dw; zacc -= atan_step[i];
        end else begin
          u += du; w -= dw; zacc += atan_step[i];
        end
      end
      u = remove_gain(u);
      w = remove_gain(w);
    end
  endfunction

  function automatic rot_vector_t rotate_about_axis(input rot_request_t req);
    longint      vx;
    longint      vy;
    longint      vz;
    rot_vector_t res;
    vx = req.x;
    vy = req.y;
    vz = req.z;
    if (req.angle != '0) begin
      case (req.axis)
        AXIS_X: turn_pair(vy, vz, req.angle);
        AXIS_Y: turn_pair(vz, vx, req.angle);
        AXIS_Z: turn_pair(vx, vy, req.angle);
        default: ;
      endcase
    end
    res.x = clamp_coord(vx);
    res.y = clamp_coord(vy);
    res.z = clamp_coord(vz);
    return res;
  endfunction

  task automatic add_request(input logic [1:0] axis, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z,
                             input logic [ANGLE_W-1:0] angle);
    rot_request_t req;
    req.axis = axis;
    req.x = x;
    req.y = y;
    req.z = z;
    req.angle = angle;
    pending_requests.push_back(req);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return 32'(int'($urandom_range(262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    logic [ANGLE_W-1:0] quarter_step;
    quarter_step = {2'($urandom_range(3)), 30'd0};
    case ($urandom_range(9))
      0: return '0;
      1: return quarter_step;
      2: return quarter_step + 32'(int'($urandom_range(64)) - 32);
      3: return quarter_step + EIGHTH + 32'(int'($urandom_range(64)) - 32);
      4: return 32'($urandom_range(1023));
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random_requests(input int count);
    logic [1:0] axis;
    for (int n = 0; n < count; n++) begin
      axis = ($urandom_range(15) == 0) ? AXIS_NONE : 2'($urandom_range(2));
      add_request(axis, pick_coord(), pick_coord(), pick_coord(), pick_angle());
    end
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endtask

  // request driver and receiver stall, both change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_requests.pop_front();
        in_req_type <= next_req.axis;
        in_x_in <= next_req.x;
        in_y_in <= next_req.y;
        in_z_in <= next_req.z;
        in_turn_angle <= next_req.angle;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      taken_req.axis = in_req_type;
      taken_req.x = in_x_in;
      taken_req.y = in_y_in;
      taken_req.z = in_z_in;
      taken_req.angle = in_turn_angle;
      expected_vectors.push_back(rotate_about_axis(taken_req));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vectors.size() == 0) begin
        flag_error($sformatf("unexpected output transfer: x=%0d y=%0d z=%0d",
                             out_x_out, out_y_out, out_z_out));
      end else begin
        want = expected_vectors.pop_front();
        if (out_x_out !== want.x || out_y_out !== want.y || out_z_out !== want.z) begin
          flag_error($sformatf("mismatch: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                               want.x, want.y, want.z, out_x_out, out_y_out, out_z_out));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((rst_n && in_valid && !in_stall) || (rst_n && out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus and phase control
  initial begin
    for (int i = 0; i < STAGES; i++) begin
      atan_step[i] = atan_turns(i);
    end

    // zero angle leaves the vector exact
    add_request(AXIS_X, COORD_MAX, COORD_MIN, COORD_MAX, '0);
    add_request(AXIS_Y, COORD_MIN, COORD_MAX, COORD_MIN, '0);
    add_request(AXIS_Z, COORD_MIN, COORD_MIN, COORD_MAX, '0);
    // exact quarter turns, negating the most negative value saturates
    add_request(AXIS_X, 32'sd1, COORD_MIN, COORD_MAX, QUARTER);
    add_request(AXIS_Y, COORD_MIN, 32'sd5, COORD_MIN, HALF);
    add_request(AXIS_Z, COORD_MIN, COORD_MAX, 32'sd7, THREE_QUARTER);
    add_request(AXIS_Z, COORD_MAX, COORD_MIN, 32'sd3, QUARTER);
    // unused axis code passes the vector through
    add_request(AXIS_NONE, 32'sd123, -32'sd456, 32'sd789, 32'h12345678);
    add_request(AXIS_NONE, COORD_MIN, COORD_MAX, COORD_MIN, HALF);
    // angle extremes and octant boundaries
    add_request(AXIS_Z, 32'sh00010000, '0, '0, 32'hFFFFFFFF);
    add_request(AXIS_X, '0, 32'sh00010000, '0, 32'h00000001);
    add_request(AXIS_Y, 32'sh00010000, 32'sh00010000, 32'sh00010000, EIGHTH);
    add_request(AXIS_Y, 32'sh00010000, 32'sh00010000, 32'sh00010000, EIGHTH - 32'd1);
    add_request(AXIS_X, '0, COORD_MIN, COORD_MIN, 32'hE0000000);
    add_request(AXIS_Y, 32'sh00010000, 32'sh00018000, 32'shFFFF0000, 32'h60000000);
    // cordic result beyond full scale saturates
    add_request(AXIS_Z, COORD_MAX, COORD_MAX, '0, EIGHTH);
    add_request(AXIS_Z, COORD_MAX, COORD_MAX, COORD_MAX, 32'hA0000000);
    add_request(AXIS_X, COORD_MIN, COORD_MIN, COORD_MIN, 32'h60000000);
    // assorted corner values
    add_request(AXIS_Z, '0, '0, '0, 32'h9ABCDEF0);
    add_request(AXIS_X, -32'sd1, -32'sd1, -32'sd1, QUARTER + 32'd1);
    add_request(AXIS_X, 32'sh5555AAAA, 32'shAAAA5555, 32'sh0F0F0F0F, 32'hFFFFFFFF);
    add_request(AXIS_Y, 32'shAAAA5555, 32'sh0F0F0F0F, 32'sh5555AAAA, 32'h55555555);

    // no idling during the first phase
    add_random_requests(RANDOM_PER_PHASE);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 1; phase < 4; phase++) begin
      while (pending_requests.size() != 0) @(posedge clk);
      case (phase)
        1: begin
          send_idle_pct = 57; recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0; recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct = 11; recv_stall_pct = 11;
        end
      endcase
      add_random_requests(RANDOM_PER_PHASE);
    end

    // drain the pipeline, then watch for stray outputs
    while (pending_requests.size() != 0 || in_valid || expected_vectors.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/vecrot_pkg.sv
hw/rtl/vector_axis_rotation_core.sv
tb/vector_axis_rotation_core_tb.sv
